[rtl/core/history_replay_session_tracker_macros.svh]
// Assertion macros shared by the history replay session tracker RTL.
// Users must provide clk and arst_n in the enclosing module.
`ifndef HISTORY_REPLAY_SESSION_TRACKER_MACROS_SVH
`define HISTORY_REPLAY_SESSION_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HRST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define HRST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/hrst_pkg.sv]
// Types and codes for the history replay session tracker.
// No dependencies; used by hrst_cfg, hrst_core and the top level.
package hrst_pkg;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_SEEKING   = 4'd1,
		PH_REQUESTED = 4'd2,
		PH_REPLAYING = 4'd3,
		PH_DONE      = 4'd4,
		PH_EMPTY     = 4'd5,
		PH_BUSY      = 4'd6,
		PH_FAILED    = 4'd7,
		PH_NO_ROUTER = 4'd8,
		PH_TIMEOUT   = 4'd9
	} phase_t;

	// event kinds
	localparam logic [2:0] FN_SENT   = 3'd0;
	localparam logic [2:0] FN_FAIL   = 3'd1;
	localparam logic [2:0] FN_STORED = 3'd2;
	localparam logic [2:0] FN_FRAME  = 3'd3;
	localparam logic [2:0] FN_TICK   = 3'd4;

	// router frame kinds
	localparam logic [3:0] FK_HEARTBEAT = 4'd0;
	localparam logic [3:0] FK_PONG      = 4'd1;
	localparam logic [3:0] FK_HISTORY   = 4'd2;
	localparam logic [3:0] FK_TEXT_DM   = 4'd3;
	localparam logic [3:0] FK_TEXT_BC   = 4'd4;
	localparam logic [3:0] FK_BUSY      = 4'd5;
	localparam logic [3:0] FK_ERROR     = 4'd6;
	localparam logic [3:0] FK_STATS     = 4'd7;

	// result event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_ROUTER  = 3'd1;
	localparam logic [2:0] EV_HISTORY = 3'd2;
	localparam logic [2:0] EV_TEXT    = 3'd3;
	localparam logic [2:0] EV_REFUSED = 3'd4;
	localparam logic [2:0] EV_STATS   = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_SEEK    = 2'd0;
	localparam logic [1:0] REG_REQUEST = 2'd1;
	localparam logic [1:0] REG_GAP     = 2'd2;

	localparam int unsigned CFG_AW    = 4;
	localparam int unsigned S_DATA_W  = 272;
	localparam int unsigned S_USER_W  = 8;
	localparam int unsigned M_DATA_W  = 240;
	localparam int unsigned M_USER_W  = 4;

	localparam logic [31:0] SEEK_RST    = 32'd30000;
	localparam logic [31:0] REQUEST_RST = 32'd60000;
	localparam logic [31:0] GAP_RST     = 32'd60000;

	typedef struct packed {
		logic [31:0] seek_ms;
		logic [31:0] request_ms;
		logic [31:0] gap_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  func;
		logic        ping;
		logic [3:0]  frame_kind;
		logic [63:0] now_ms;
		logic [31:0] now_s;
		logic [31:0] node;
		logic [7:0]  channel;
		logic        variant_ok;
		logic [31:0] rx_time;
		logic [31:0] count_value;
		logic [31:0] cursor_value;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] router_id;
		logic [7:0]  router_chan;
		logic [31:0] heard_s;
		logic [31:0] expected;
		logic [31:0] received;
		logic [31:0] stored;
		logic [31:0] cursor;
		logic        followup;
		logic [31:0] period;
		logic [63:0] last_ms;
	} state_t;

endpackage

[rtl/core/hrst_cfg.sv]
// APB-style register file for the three timeout settings.
// Depends on hrst_pkg.
module hrst_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hrst_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output hrst_pkg::cfg_t              cfg
);

	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.seek_ms    <= hrst_pkg::SEEK_RST;
			cfg.request_ms <= hrst_pkg::REQUEST_RST;
			cfg.gap_ms     <= hrst_pkg::GAP_RST;
		end else if (wr_en) begin
			case (idx)
				hrst_pkg::REG_SEEK:    cfg.seek_ms    <= pwdata;
				hrst_pkg::REG_REQUEST: cfg.request_ms <= pwdata;
				hrst_pkg::REG_GAP:     cfg.gap_ms     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			hrst_pkg::REG_SEEK:    prdata = cfg.seek_ms;
			hrst_pkg::REG_REQUEST: prdata = cfg.request_ms;
			hrst_pkg::REG_GAP:     prdata = cfg.gap_ms;
			default:               prdata = 32'h0;
		endcase
	end

endmodule

[rtl/core/hrst_core.sv]
// Session state registers and the per-word update logic.
// Depends on hrst_pkg.
module hrst_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  hrst_pkg::item_t  item,
	input  hrst_pkg::cfg_t   cfg,
	output hrst_pkg::state_t st,
	output logic [2:0]       ev,
	output logic             fired
);

	hrst_pkg::state_t st_q;
	hrst_pkg::state_t nx;
	logic             running;
	logic             keep_router;
	logic             note;
	logic [31:0]      heard;
	logic [31:0]      recv_inc;
	logic [63:0]      since;

	assign st = st_q;

	assign running = (st_q.phase == hrst_pkg::PH_REQUESTED) ||
		(st_q.phase == hrst_pkg::PH_REPLAYING);
	// first router heard wins while a request runs
	assign keep_router = running && (st_q.router_id != 32'h0) &&
		(st_q.router_id != item.node);
	assign heard    = (item.rx_time != 32'h0) ? item.rx_time : item.now_s;
	assign recv_inc = (st_q.received == 32'hFFFF_FFFF) ? st_q.received :
		st_q.received + 32'd1;
	// backwards time counts as no elapsed time
	assign since = (item.now_ms > st_q.last_ms) ? item.now_ms - st_q.last_ms : 64'h0;

	always_comb begin
		nx    = st_q;
		ev    = hrst_pkg::EV_NONE;
		fired = 1'b0;
		note  = 1'b0;
		case (item.func)
			hrst_pkg::FN_SENT: begin
				nx.last_ms  = item.now_ms;
				nx.expected = 32'h0;
				nx.received = 32'h0;
				nx.stored   = 32'h0;
				nx.followup = 1'b0;
				if (item.ping) begin
					nx.phase = hrst_pkg::PH_SEEKING;
				end else begin
					nx.phase       = hrst_pkg::PH_REQUESTED;
					nx.router_id   = item.node;
					nx.router_chan = item.channel;
				end
			end
			hrst_pkg::FN_FAIL: begin
				nx.followup = 1'b0;
				nx.phase    = hrst_pkg::PH_FAILED;
			end
			hrst_pkg::FN_STORED: begin
				if (st_q.stored != 32'hFFFF_FFFF) begin
					nx.stored = st_q.stored + 32'd1;
				end
			end
			hrst_pkg::FN_FRAME: begin
				if (st_q.phase == hrst_pkg::PH_SEEKING &&
					(item.frame_kind == hrst_pkg::FK_HEARTBEAT ||
					item.frame_kind == hrst_pkg::FK_PONG)) begin
					nx.followup = 1'b1;
				end
				case (item.frame_kind)
					hrst_pkg::FK_HEARTBEAT: begin
						note = 1'b1;
						if (item.variant_ok) begin
							nx.period = item.count_value;
						end
						ev = hrst_pkg::EV_ROUTER;
					end
					hrst_pkg::FK_PONG: begin
						note       = 1'b1;
						nx.last_ms = item.now_ms;
						ev         = hrst_pkg::EV_ROUTER;
					end
					hrst_pkg::FK_HISTORY: begin
						note       = 1'b1;
						nx.last_ms = item.now_ms;
						if (item.variant_ok) begin
							nx.expected = item.count_value;
							nx.cursor   = item.cursor_value;
						end
						nx.received = 32'h0;
						nx.stored   = 32'h0;
						nx.phase    = (nx.expected == 32'h0) ? hrst_pkg::PH_EMPTY :
							hrst_pkg::PH_REPLAYING;
						ev          = hrst_pkg::EV_HISTORY;
					end
					hrst_pkg::FK_TEXT_DM, hrst_pkg::FK_TEXT_BC: begin
						if (item.variant_ok) begin
							nx.last_ms  = item.now_ms;
							nx.received = recv_inc;
							nx.phase    = (st_q.expected != 32'h0 &&
								recv_inc >= st_q.expected) ? hrst_pkg::PH_DONE :
								hrst_pkg::PH_REPLAYING;
							ev          = hrst_pkg::EV_TEXT;
						end
					end
					hrst_pkg::FK_BUSY: begin
						note       = 1'b1;
						nx.last_ms = item.now_ms;
						nx.phase   = hrst_pkg::PH_BUSY;
						ev         = hrst_pkg::EV_REFUSED;
					end
					hrst_pkg::FK_ERROR: begin
						note       = 1'b1;
						nx.last_ms = item.now_ms;
						nx.phase   = hrst_pkg::PH_FAILED;
						ev         = hrst_pkg::EV_REFUSED;
					end
					hrst_pkg::FK_STATS: begin
						note = 1'b1;
						ev   = hrst_pkg::EV_STATS;
					end
					default: ;
				endcase
				if (note && !keep_router) begin
					nx.router_id   = item.node;
					nx.router_chan = item.channel;
					nx.heard_s     = heard;
				end
			end
			hrst_pkg::FN_TICK: begin
				case (st_q.phase)
					hrst_pkg::PH_SEEKING: begin
						if (since >= {32'h0, cfg.seek_ms}) begin
							nx.followup = 1'b0;
							nx.phase    = hrst_pkg::PH_NO_ROUTER;
							fired       = 1'b1;
						end
					end
					hrst_pkg::PH_REQUESTED: begin
						if (since >= {32'h0, cfg.request_ms}) begin
							nx.phase       = hrst_pkg::PH_TIMEOUT;
							nx.router_id   = 32'h0;
							nx.router_chan = 8'h0;
							nx.cursor      = 32'h0;
							fired          = 1'b1;
						end
					end
					hrst_pkg::PH_REPLAYING: begin
						if (since >= {32'h0, cfg.gap_ms}) begin
							nx.phase = hrst_pkg::PH_DONE;
							fired    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nx;
		end
	end

endmodule

[rtl/core/history_replay_session_tracker.sv]
// Path: input register, update logic, result register; a word advances from the input
// register when the result register is empty or drained. Throughput: one word per cycle
// unless the result word stalls. The session state registers are updated as the result
// register loads, so they double as the result payload. Reset clears all state and the
// valid flags at once, and loads the timeouts with 30000, 60000 and 60000 ms.
module history_replay_session_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// now_ms, now_s, req_tag, node, channel, variant_ok, rx_time,
	// count_value, cursor_value, zero pad
	input  logic [hrst_pkg::S_DATA_W-1:0] s_tdata,
	// func, ping, frame_kind
	input  logic [hrst_pkg::S_USER_W-1:0] s_tuser,
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// session_state, router_node, router_chan, router_heard_s, expected_count,
	// received_count, stored_count, next_cursor, followup_flag, beat_period, zero pad
	output logic [hrst_pkg::M_DATA_W-1:0] m_tdata,
	// event_res, tick_fired
	output logic [hrst_pkg::M_USER_W-1:0] m_tuser,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hrst_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

`include "history_replay_session_tracker_macros.svh"

	hrst_pkg::cfg_t   cfg;
	hrst_pkg::item_t  in_item;
	hrst_pkg::item_t  item_s1;
	hrst_pkg::state_t st;
	logic             valid_s1;
	logic             adv;
	logic [2:0]       ev;
	logic             fired;
	logic [2:0]       ev_q;
	logic             fired_q;

	assign in_item.func         = s_tuser[2:0];
	assign in_item.ping         = s_tuser[3];
	assign in_item.frame_kind   = s_tuser[7:4];
	assign in_item.now_ms       = s_tdata[63:0];
	assign in_item.now_s        = s_tdata[95:64];
	assign in_item.node         = s_tdata[159:128];
	assign in_item.channel      = s_tdata[167:160];
	assign in_item.variant_ok   = s_tdata[168];
	assign in_item.rx_time      = s_tdata[200:169];
	assign in_item.count_value  = s_tdata[232:201];
	assign in_item.cursor_value = s_tdata[264:233];

	// advance when the result register is empty or being drained
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item;
		end
	end

	hrst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hrst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.st     (st),
		.ev     (ev),
		.fired  (fired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			ev_q     <= hrst_pkg::EV_NONE;
			fired_q  <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid <= 1'b1;
				ev_q     <= ev;
				fired_q  <= fired;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign m_tuser = {fired_q, ev_q};
	assign m_tdata = {3'b000, st.period, st.followup, st.cursor, st.stored, st.received,
		st.expected, st.heard_s, st.router_chan, st.router_id, st.phase};

	`HRST_ASSERT_NEXT(a_adv_loads_result, adv, m_tvalid,
		"advanced word did not reach the result register")
	`HRST_ASSERT_NEXT(a_stall_holds_state, m_tvalid && !m_tready, $stable(st),
		"session state changed while the result word was stalled")
	`HRST_ASSERT_NOW(a_fired_is_timeout, m_tvalid && fired_q,
		ev_q == hrst_pkg::EV_NONE && (st.phase == hrst_pkg::PH_DONE ||
		st.phase == hrst_pkg::PH_NO_ROUTER || st.phase == hrst_pkg::PH_TIMEOUT),
		"timeout flag with an event or a non-terminal phase")
	`HRST_ASSERT_NOW(a_timeout_clears_router,
		m_tvalid && fired_q && st.phase == hrst_pkg::PH_TIMEOUT,
		st.router_id == 32'h0 && st.cursor == 32'h0,
		"request timeout left router or cursor set")

endmodule

[tb/hrst_session_checker.sv]
// Session checker for the history replay session tracker: predicts every result word
// from the accepted event words and configuration writes, and compares field by field.
// Depends on hrst_pkg for event, frame and phase codes and the bus widths.
module hrst_session_checker
	import hrst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [S_USER_W-1:0] s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic [M_USER_W-1:0] m_tuser,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output int unsigned         errors,
	output int unsigned         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  ev;
		logic        fired;
		phase_t      phase;
		logic [31:0] node;
		logic [7:0]  chan;
		logic [31:0] heard;
		logic [31:0] expected;
		logic [31:0] received;
		logic [31:0] stored;
		logic [31:0] cursor;
		logic        followup;
		logic [31:0] period;
	} snapshot_t;

	phase_t      ph;
	logic [31:0] rt_node;
	logic [7:0]  rt_chan;
	logic [31:0] rt_heard;
	logic [31:0] exp_cnt;
	logic [31:0] rcv_cnt;
	logic [31:0] sto_cnt;
	logic [31:0] cursor;
	logic        followup;
	logic [31:0] period;
	logic [63:0] last_ms;
	logic [31:0] seek_lim;
	logic [31:0] req_lim;
	logic [31:0] gap_lim;
	snapshot_t   snapshots[$];

	// while a request runs, keep the first router heard
	function automatic void note_router(input logic [31:0] who, input logic [7:0] chan,
			input logic [31:0] rxt, input logic [31:0] nows);
		logic running;
		running = (ph == PH_REQUESTED) || (ph == PH_REPLAYING);
		if (!(running && rt_node != 32'd0 && rt_node != who)) begin
			rt_node = who;
			rt_chan = chan;
			rt_heard = (rxt != 32'd0) ? rxt : nows;
		end
	endfunction

	task automatic advance_session(input logic [S_DATA_W-1:0] d, input logic [S_USER_W-1:0] u,
			output snapshot_t s);
		logic [2:0]  fn;
		logic        ping;
		logic [3:0]  kind;
		logic [63:0] now_ms;
		logic [31:0] now_s;
		logic [31:0] who;
		logic [7:0]  chan;
		logic        ok;
		logic [31:0] rxt;
		logic [31:0] cnt;
		logic [31:0] cur;
		logic [63:0] since;
		fn = u[2:0];
		ping = u[3];
		kind = u[7:4];
		now_ms = d[63:0];
		now_s = d[95:64];
		who = d[159:128];
		chan = d[167:160];
		ok = d[168];
		rxt = d[200:169];
		cnt = d[232:201];
		cur = d[264:233];
		s.ev = EV_NONE;
		s.fired = 1'b0;
		case (fn)
		FN_SENT: begin
			last_ms = now_ms;
			exp_cnt = '0;
			rcv_cnt = '0;
			sto_cnt = '0;
			followup = 1'b0;
			if (ping) begin
				ph = PH_SEEKING;
			end else begin
				ph = PH_REQUESTED;
				rt_node = who;
				rt_chan = chan;
			end
		end
		FN_FAIL: begin
			followup = 1'b0;
			ph = PH_FAILED;
		end
		FN_STORED: begin
			if (sto_cnt != '1)
				sto_cnt++;
		end
		FN_FRAME: begin
			if (ph == PH_SEEKING && (kind == FK_HEARTBEAT || kind == FK_PONG))
				followup = 1'b1;
			case (kind)
			FK_HEARTBEAT: begin
				note_router(who, chan, rxt, now_s);
				if (ok)
					period = cnt;
				s.ev = EV_ROUTER;
			end
			FK_PONG: begin
				note_router(who, chan, rxt, now_s);
				last_ms = now_ms;
				s.ev = EV_ROUTER;
			end
			FK_HISTORY: begin
				note_router(who, chan, rxt, now_s);
				last_ms = now_ms;
				if (ok) begin
					exp_cnt = cnt;
					cursor = cur;
				end
				rcv_cnt = '0;
				sto_cnt = '0;
				ph = (exp_cnt == '0) ? PH_EMPTY : PH_REPLAYING;
				s.ev = EV_HISTORY;
			end
			FK_TEXT_DM, FK_TEXT_BC: begin
				if (ok) begin
					last_ms = now_ms;
					if (rcv_cnt != '1)
						rcv_cnt++;
					ph = (exp_cnt != '0 && rcv_cnt >= exp_cnt) ? PH_DONE : PH_REPLAYING;
					s.ev = EV_TEXT;
				end
			end
			FK_BUSY: begin
				note_router(who, chan, rxt, now_s);
				last_ms = now_ms;
				ph = PH_BUSY;
				s.ev = EV_REFUSED;
			end
			FK_ERROR: begin
				note_router(who, chan, rxt, now_s);
				last_ms = now_ms;
				ph = PH_FAILED;
				s.ev = EV_REFUSED;
			end
			FK_STATS: begin
				note_router(who, chan, rxt, now_s);
				s.ev = EV_STATS;
			end
			default: ;
			endcase
		end
		FN_TICK: begin
			// time running backwards counts as no silence
			since = (now_ms > last_ms) ? now_ms - last_ms : 64'd0;
			if (ph == PH_SEEKING && since >= {32'd0, seek_lim}) begin
				followup = 1'b0;
				ph = PH_NO_ROUTER;
				s.fired = 1'b1;
			end else if (ph == PH_REQUESTED && since >= {32'd0, req_lim}) begin
				ph = PH_TIMEOUT;
				rt_node = '0;
				rt_chan = '0;
				cursor = '0;
				s.fired = 1'b1;
			end else if (ph == PH_REPLAYING && since >= {32'd0, gap_lim}) begin
				ph = PH_DONE;
				s.fired = 1'b1;
			end
		end
		default: ;
		endcase
		s.phase = ph;
		s.node = rt_node;
		s.chan = rt_chan;
		s.heard = rt_heard;
		s.expected = exp_cnt;
		s.received = rcv_cnt;
		s.stored = sto_cnt;
		s.cursor = cursor;
		s.followup = followup;
		s.period = period;
	endtask

	function automatic int unsigned mismatch(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		snapshot_t want;
		if (!arst_n) begin
			ph = PH_IDLE;
			rt_node = '0;
			rt_chan = '0;
			rt_heard = '0;
			exp_cnt = '0;
			rcv_cnt = '0;
			sto_cnt = '0;
			cursor = '0;
			followup = 1'b0;
			period = '0;
			last_ms = '0;
			seek_lim = SEEK_RST;
			req_lim = REQUEST_RST;
			gap_lim = GAP_RST;
			snapshots.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (paddr[3:2])
				REG_SEEK: seek_lim = pwdata;
				REG_REQUEST: req_lim = pwdata;
				REG_GAP: gap_lim = pwdata;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				advance_session(s_tdata, s_tuser, want);
				snapshots.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (snapshots.size() == 0) begin
					errors++;
					$display("%0t: result word expected none, got %0h / %0h", $time,
						m_tuser, m_tdata);
				end else begin
					want = snapshots.pop_front();
					errors += mismatch("event_res", 64'(want.ev), 64'(m_tuser[2:0]));
					errors += mismatch("tick_fired", 64'(want.fired), 64'(m_tuser[3]));
					errors += mismatch("session_state", 64'(want.phase), 64'(m_tdata[3:0]));
					errors += mismatch("router_node", 64'(want.node), 64'(m_tdata[35:4]));
					errors += mismatch("router_chan", 64'(want.chan), 64'(m_tdata[43:36]));
					errors += mismatch("router_heard_s", 64'(want.heard),
						64'(m_tdata[75:44]));
					errors += mismatch("expected_count", 64'(want.expected),
						64'(m_tdata[107:76]));
					errors += mismatch("received_count", 64'(want.received),
						64'(m_tdata[139:108]));
					errors += mismatch("stored_count", 64'(want.stored),
						64'(m_tdata[171:140]));
					errors += mismatch("next_cursor", 64'(want.cursor),
						64'(m_tdata[203:172]));
					errors += mismatch("followup_flag", 64'(want.followup),
						64'(m_tdata[204]));
					errors += mismatch("beat_period", 64'(want.period),
						64'(m_tdata[236:205]));
				end
			end
			outstanding <= snapshots.size();
		end
	end

endmodule

[tb/tb_history_replay_session_tracker.sv]
// Top of the history replay session tracker testbench: clock, reset, event words,
// register writes, random stalls and the verdict. Depends on hrst_pkg, the tracker
// RTL and hrst_session_checker.
module tb_history_replay_session_tracker;
	import hrst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	// event and frame kinds the tracker ignores
	localparam logic [2:0] FN_RESERVED = 3'd7;
	localparam logic [3:0] FK_OTHER    = 4'd8;
	localparam logic [3:0] FK_TOP      = 4'd15;

	typedef struct packed {
		logic [2:0]  func;
		logic        ping;
		logic [3:0]  kind;
		logic [63:0] now_ms;
		logic [31:0] now_s;
		logic [31:0] req_tag;
		logic [31:0] node;
		logic [7:0]  channel;
		logic        ok;
		logic [31:0] rx_time;
		logic [31:0] count_value;
		logic [31:0] cursor_value;
	} event_word_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CFG_AW-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	int unsigned         errors;
	int unsigned         outstanding;
	int unsigned         cycle_count = 0;
	int unsigned         words_sent = 0;
	int unsigned         step_max = 40000;
	logic [63:0]         t_ms = 64'd1000;
	bit                  calm = 1'b0;

	history_replay_session_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	hrst_session_checker session_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("history_replay_session_tracker regression: fail");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(99) >= 17);
	end

	function automatic event_word_t make_word(input logic [2:0] fn, input logic [3:0] kind,
			input logic ping, input logic ok, input logic [63:0] now, input logic [31:0] who,
			input logic [31:0] cnt);
		event_word_t w;
		w.func = fn;
		w.kind = kind;
		w.ping = ping;
		w.ok = ok;
		w.now_ms = now;
		w.node = who;
		w.count_value = cnt;
		w.now_s = $urandom;
		w.req_tag = $urandom;
		w.channel = 8'($urandom_range(255));
		w.rx_time = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
		w.cursor_value = $urandom;
		return w;
	endfunction

	function automatic event_word_t noise_word();
		event_word_t w;
		w = make_word(3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)),
			1'($urandom_range(1)), {$urandom, $urandom}, $urandom, $urandom);
		return w;
	endfunction

	// a few recurring routers so that first-heard and newest-heard both matter
	function automatic logic [31:0] pick_node();
		case ($urandom_range(4))
		0: return 32'd0;
		1: return 32'd1;
		2: return 32'd2;
		3: return 32'hA5A5_0003;
		default: return $urandom;
		endcase
	endfunction

	task automatic send(input event_word_t w);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		// 7 pad bits on top
		s_tdata <= {7'd0, w.cursor_value, w.count_value, w.rx_time, w.ok, w.channel,
			w.node, w.req_tag, w.now_s, w.now_ms};
		s_tuser <= {w.kind, w.ping, w.func};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// hold the sender until every result word is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] seek, input logic [31:0] req,
			input logic [31:0] gap);
		drain();
		write_reg(REG_SEEK, seek);
		write_reg(REG_REQUEST, req);
		write_reg(REG_GAP, gap);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic pass_time();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4)
			t_ms -= 64'($urandom_range(step_max));
		else if (r < 7)
			t_ms += 64'h1_0000_0000 + 64'($urandom_range(step_max));
		else
			t_ms += 64'($urandom_range(step_max));
	endtask

	// optional ping, history request, optional frame or tick, history answer, then replay traffic
	task automatic replay_session();
		logic [31:0] home;
		int unsigned n;
		int unsigned r;
		home = pick_node();
		if ($urandom_range(1)) begin
			pass_time();
			send(make_word(FN_SENT, FK_HEARTBEAT, 1'b1, 1'b1, t_ms, home, 32'd0));
			n = $urandom_range(2);
			repeat (n) begin
				pass_time();
				send(make_word(FN_FRAME, $urandom_range(1) ? FK_PONG : FK_HEARTBEAT, 1'b0,
					1'($urandom_range(1)), t_ms, pick_node(), $urandom_range(9000)));
			end
			if ($urandom_range(2) == 0) begin
				pass_time();
				send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, t_ms, 32'd0, 32'd0));
			end
		end
		pass_time();
		send(make_word(FN_SENT, FK_HEARTBEAT, 1'b0, 1'b0, t_ms, home, 32'd0));
		if ($urandom_range(3) == 0) begin
			pass_time();
			send(make_word(FN_FRAME, $urandom_range(1) ? FK_STATS : FK_HEARTBEAT, 1'b0,
				1'($urandom_range(1)), t_ms, pick_node(), $urandom_range(9000)));
		end
		if ($urandom_range(5) == 0) begin
			pass_time();
			send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, t_ms, 32'd0, 32'd0));
		end
		pass_time();
		send(make_word(FN_FRAME, FK_HISTORY, 1'b0, $urandom_range(9) != 0, t_ms, home,
			$urandom_range(6)));
		n = $urandom_range(10);
		repeat (n) begin
			pass_time();
			r = $urandom_range(99);
			if (r < 45)
				send(make_word(FN_FRAME, $urandom_range(1) ? FK_TEXT_DM : FK_TEXT_BC, 1'b0,
					$urandom_range(7) != 0, t_ms, home, $urandom));
			else if (r < 65)
				send(make_word(FN_STORED, FK_HEARTBEAT, 1'b0, 1'b0, t_ms, home, 32'd0));
			else if (r < 80)
				send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, t_ms, 32'd0, 32'd0));
			else if (r < 85)
				send(make_word(FN_FRAME, $urandom_range(1) ? FK_BUSY : FK_ERROR, 1'b0,
					1'($urandom_range(1)), t_ms, home, $urandom));
			else if (r < 90)
				send(make_word(FN_FAIL, FK_HEARTBEAT, 1'b0, 1'b0, t_ms, home, 32'd0));
			else if (r < 95)
				send(make_word(FN_FRAME, $urandom_range(1) ? FK_STATS : FK_HEARTBEAT, 1'b0,
					1'($urandom_range(1)), t_ms, pick_node(), $urandom));
			else
				send(noise_word());
		end
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned first;
		first = words_sent;
		while (words_sent - first < quota) begin
			if ($urandom_range(9) == 0)
				send(noise_word());
			else
				replay_session();
		end
	endtask

	initial begin
		event_word_t w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset timeouts
		send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, 64'd0, 32'd0, 32'd0));
		send(make_word(FN_RESERVED, FK_HEARTBEAT, 1'b1, 1'b1, 64'd5, 32'h11, 32'd7));
		send(make_word(FN_SENT, FK_HEARTBEAT, 1'b1, 1'b0, 64'd1000, 32'h10, 32'd0));
		w = make_word(FN_FRAME, FK_HEARTBEAT, 1'b0, 1'b0, 64'd1000, 32'h21, 32'd77);
		w.rx_time = 32'd0;
		send(w);
		w = make_word(FN_FRAME, FK_PONG, 1'b0, 1'b1, 64'd1000, 32'h22, 32'd0);
		w.rx_time = 32'hFFFF_FFFF;
		send(w);
		send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, 64'd30999, 32'd0, 32'd0));
		send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, 64'd31000, 32'd0, 32'd0));
		send(make_word(FN_SENT, FK_HEARTBEAT, 1'b0, 1'b0, 64'd40000, 32'h30, 32'd0));
		// a second router during a running request is not taken
		send(make_word(FN_FRAME, FK_HEARTBEAT, 1'b0, 1'b1, 64'd40001, 32'h31, 32'd500));
		send(make_word(FN_FRAME, FK_HISTORY, 1'b0, 1'b1, 64'd40002, 32'h30, 32'd3));
		send(make_word(FN_FRAME, FK_TEXT_DM, 1'b0, 1'b1, 64'd40003, 32'h30, 32'd0));
		send(make_word(FN_FRAME, FK_TEXT_BC, 1'b0, 1'b0, 64'd40004, 32'h30, 32'd0));
		send(make_word(FN_STORED, FK_HEARTBEAT, 1'b0, 1'b0, 64'd40005, 32'h30, 32'd0));
		send(make_word(FN_FRAME, FK_TEXT_BC, 1'b0, 1'b1, 64'd40006, 32'h30, 32'd0));
		send(make_word(FN_FRAME, FK_TEXT_DM, 1'b0, 1'b1, 64'd40007, 32'h30, 32'd0));
		send(make_word(FN_FRAME, FK_OTHER, 1'b0, 1'b1, 64'd40008, 32'h99, 32'd1));
		send(make_word(FN_FRAME, FK_TOP, 1'b1, 1'b1, 64'd40009, 32'h99, 32'd1));
		send(make_word(FN_FRAME, FK_STATS, 1'b0, 1'b0, 64'd40010, 32'h40, 32'd0));
		send(make_word(FN_SENT, FK_HEARTBEAT, 1'b0, 1'b0, 64'd50000, 32'h50, 32'd0));
		// history without body keeps the old count of zero
		send(make_word(FN_FRAME, FK_HISTORY, 1'b0, 1'b0, 64'd50001, 32'h50, 32'd9));
		send(make_word(FN_SENT, FK_HEARTBEAT, 1'b0, 1'b0, 64'd60000, 32'h51, 32'd0));
		send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, 64'd10, 32'd0, 32'd0));
		send(make_word(FN_TICK, FK_HEARTBEAT, 1'b0, 1'b0, 64'd120000, 32'd0, 32'd0));
		send(make_word(FN_FRAME, FK_BUSY, 1'b0, 1'b1, 64'd120001, 32'h60, 32'd0));
		send(make_word(FN_FRAME, FK_ERROR, 1'b0, 1'b0, 64'd120002, 32'h61, 32'd0));
		send(make_word(FN_FAIL, FK_HEARTBEAT, 1'b0, 1'b0, 64'd120003, 32'h61, 32'd0));
		w = '1;
		send(w);
		w = '0;
		send(w);

		configure(32'd1, 32'd1, 32'd1);
		step_max = 4;
		random_phase(100);

		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		step_max = 100000;
		random_phase(80);

		configure($urandom_range(1, 50000), $urandom_range(1, 50000), $urandom_range(1, 50000));
		step_max = 30000;
		calm = 1'b1;
		random_phase(75);
		calm = 1'b0;

		configure($urandom_range(1, 50000), $urandom_range(1, 50000), $urandom_range(1, 50000));
		random_phase(75);

		configure($urandom_range(1, 5000), $urandom_range(1, 50000), $urandom_range(1, 500));
		step_max = 3000;
		random_phase(75);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("history_replay_session_tracker regression: pass");
		else
			$display("history_replay_session_tracker regression: fail");
		$finish;
	end

endmodule
